[rtl/qvr_pkg.sv]
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types, component indexes and width helpers for the quaternion
// vector rotate unit.
// ----------------------------------------------------------------------------
package qvr_pkg;

   // Quaternion components are Q1.14, 16-bit two's complement
   localparam int QUAT_WIDTH = 16;

   typedef logic signed [QUAT_WIDTH-1:0] quat_comp_type;

   typedef struct packed {
      quat_comp_type x;
      quat_comp_type y;
      quat_comp_type z;
      quat_comp_type s;
   } quat_type;

   // Operand component slots (vector x/y/z/w, quaternion x/y/z/s)
   localparam int IDX_X = 0;
   localparam int IDX_Y = 1;
   localparam int IDX_Z = 2;
   localparam int IDX_W = 3;
   localparam int IDX_S = 3;

   // Accumulator width for a four-term sum of products, kept wide enough
   // that the rounded, shifted result always has a sign bit and one more
   function automatic int sum_width(input int prod_width, input int frac);
      if (prod_width + 3 > frac + 2) begin
         return prod_width + 3;
      end
      return frac + 2;
   endfunction

endpackage

[rtl/quaternion_vector_rotate_unit.sv]
// An accepted request beat passes through five register stages (multiply,
// sum, multiply, sum, saturate) before it is the response beat. Throughput:
// one rotation per cycle while rsp_stall is low; a stage advances when it is
// empty or the stage after it moves, so empty stages still take beats in a stall.
// Reset: synchronous, active high; clears every stage valid bit, so the
// pipeline comes up empty and takes a beat in the first cycle after reset.
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit
// Rotates a 3-vector by a Q1.14 quaternion as q * (v,0) * conj(q), with
// round-to-nearest after each product and saturation of the result.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit #(
   parameter int VEC_WIDTH = 24,
   parameter int QUAT_FRAC = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] req_quat_x,
   input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] req_quat_y,
   input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] req_quat_z,
   input  logic signed [qvr_pkg::QUAT_WIDTH-1:0] req_quat_s,
   input  logic signed [VEC_WIDTH-1:0]         req_vec_x,
   input  logic signed [VEC_WIDTH-1:0]         req_vec_y,
   input  logic signed [VEC_WIDTH-1:0]         req_vec_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [VEC_WIDTH-1:0]         rsp_rot_x,
   output logic signed [VEC_WIDTH-1:0]         rsp_rot_y,
   output logic signed [VEC_WIDTH-1:0]         rsp_rot_z,
   output logic                                rsp_clipped
);
   import qvr_pkg::*;

   // Widths of the intermediate product t = q * (v,0) and of the final sum
   localparam int PW1 = VEC_WIDTH + QUAT_WIDTH;
   localparam int TW  = sum_width(PW1, QUAT_FRAC) - QUAT_FRAC;
   localparam int PW2 = TW + QUAT_WIDTH;
   localparam int RW2 = sum_width(PW2, QUAT_FRAC) - QUAT_FRAC;

   quat_type              req_quat;
   quat_type              quat1, quat2, quat3;
   logic                  v1, v2, v3, v4, v5;
   logic                  en1, en2, en3, en4, en5;
   logic signed [PW1-1:0] prod1 [4][4];
   logic signed [PW2-1:0] prod2 [4][4];
   logic signed [TW-1:0]  t_x, t_y, t_z, t_w;
   logic signed [RW2-1:0] r_x, r_y, r_z;

   assign req_quat.x = req_quat_x;
   assign req_quat.y = req_quat_y;
   assign req_quat.z = req_quat_z;
   assign req_quat.s = req_quat_s;

   // Advance each stage when it is empty or the stage after it moves
   assign en5       = !v5 || !rsp_stall;
   assign en4       = !v4 || en5;
   assign en3       = !v3 || en4;
   assign en2       = !v2 || en3;
   assign en1       = !v1 || en2;
   assign req_stall = !en1;

   // Stage 1: v times q
   qvr_prod_stage #(.AW(VEC_WIDTH)) u_prod1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (en1),
      .valid_in  (req_valid),
      .a_x       (req_vec_x),
      .a_y       (req_vec_y),
      .a_z       (req_vec_z),
      .a_w       ('0),
      .quat_in   (req_quat),
      .valid_out (v1),
      .quat_out  (quat1),
      .prod_out  (prod1)
   );

   // Stage 2: t = q * (v,0), rounded
   qvr_round_sum #(.PW(PW1), .FRAC(QUAT_FRAC)) u_sum1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (en2),
      .valid_in  (v1),
      .prod_in   (prod1),
      .quat_in   (quat1),
      .valid_out (v2),
      .quat_out  (quat2),
      .r_x       (t_x),
      .r_y       (t_y),
      .r_z       (t_z),
      .r_w       (t_w)
   );

   // Stage 3: t times q
   qvr_prod_stage #(.AW(TW)) u_prod2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (en3),
      .valid_in  (v2),
      .a_x       (t_x),
      .a_y       (t_y),
      .a_z       (t_z),
      .a_w       (t_w),
      .quat_in   (quat2),
      .valid_out (v3),
      .quat_out  (quat3),
      .prod_out  (prod2)
   );

   // Stage 4: vector part of t * conj(q), rounded
   qvr_round_sum #(.PW(PW2), .FRAC(QUAT_FRAC)) u_sum2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (en4),
      .valid_in  (v3),
      .prod_in   (prod2),
      .quat_in   (quat3),
      .valid_out (v4),
      .quat_out  (),
      .r_x       (r_x),
      .r_y       (r_y),
      .r_z       (r_z),
      .r_w       ()
   );

   // Stage 5: saturate and present the response beat
   qvr_saturate #(.IW(RW2), .OW(VEC_WIDTH)) u_sat (
      .clock     (clock),
      .reset     (reset),
      .advance   (en5),
      .valid_in  (v4),
      .in_x      (r_x),
      .in_y      (r_y),
      .in_z      (r_z),
      .valid_out (v5),
      .out_x     (rsp_rot_x),
      .out_y     (rsp_rot_y),
      .out_z     (rsp_rot_z),
      .clip_out  (rsp_clipped)
   );

   assign rsp_valid = v5;

endmodule

[rtl/qvr_prod_stage.sv]
// ----------------------------------------------------------------------------
// qvr_prod_stage
// Multiplier stage: forms all sixteen products of a four-component operand
// with the four quaternion components and registers them.
// ----------------------------------------------------------------------------
module qvr_prod_stage #(
   parameter int AW = 24
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      advance,
   input  logic                                      valid_in,
   input  logic signed [AW-1:0]                      a_x,
   input  logic signed [AW-1:0]                      a_y,
   input  logic signed [AW-1:0]                      a_z,
   input  logic signed [AW-1:0]                      a_w,
   input  qvr_pkg::quat_type                         quat_in,
   output logic                                      valid_out,
   output qvr_pkg::quat_type                         quat_out,
   output logic signed [AW+qvr_pkg::QUAT_WIDTH-1:0]  prod_out [4][4]
);
   import qvr_pkg::*;

   localparam int PW = AW + QUAT_WIDTH;

   logic signed [PW-1:0] a_ext [4];
   logic signed [PW-1:0] q_ext [4];
   logic signed [PW-1:0] prod_in [4][4];
   logic signed [PW-1:0] prod_ff [4][4];
   quat_type             quat_ff;
   logic                 valid_ff;

   // Sign-extend both operands to the full product width
   always_comb begin
      a_ext[IDX_X] = PW'(a_x);
      a_ext[IDX_Y] = PW'(a_y);
      a_ext[IDX_Z] = PW'(a_z);
      a_ext[IDX_W] = PW'(a_w);
      q_ext[IDX_X] = PW'(quat_in.x);
      q_ext[IDX_Y] = PW'(quat_in.y);
      q_ext[IDX_Z] = PW'(quat_in.z);
      q_ext[IDX_S] = PW'(quat_in.s);
   end

   // One multiplier per operand pair
   for (genvar i = 0; i < 4; i++) begin : g_row
      for (genvar j = 0; j < 4; j++) begin : g_col
         assign prod_in[i][j] = a_ext[i] * q_ext[j];
      end
   end

   // Advance the stage; hold the beat while the next stage is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && valid_in) begin
         prod_ff <= prod_in;
         quat_ff <= quat_in;
      end
   end

   assign valid_out = valid_ff;
   assign quat_out  = quat_ff;
   assign prod_out  = prod_ff;

endmodule

[rtl/qvr_round_sum.sv]
// ----------------------------------------------------------------------------
// qvr_round_sum
// Adder stage: combines registered products into the four components of a
// Hamilton product, rounds to nearest and drops the fraction bits.
// ----------------------------------------------------------------------------
module qvr_round_sum #(
   parameter  int PW   = 40,
   parameter  int FRAC = 14,
   localparam int RW   = qvr_pkg::sum_width(PW, FRAC) - FRAC
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   valid_in,
   input  logic signed [PW-1:0]   prod_in [4][4],
   input  qvr_pkg::quat_type      quat_in,
   output logic                   valid_out,
   output qvr_pkg::quat_type      quat_out,
   output logic signed [RW-1:0]   r_x,
   output logic signed [RW-1:0]   r_y,
   output logic signed [RW-1:0]   r_z,
   output logic signed [RW-1:0]   r_w
);
   import qvr_pkg::*;

   localparam int SW = sum_width(PW, FRAC);
   localparam logic signed [SW-1:0] RND = SW'(1) << (FRAC - 1);

   logic signed [SW-1:0] p [4][4];
   logic signed [SW-1:0] sum_x, sum_y, sum_z, sum_w;
   logic signed [RW-1:0] rx_in, ry_in, rz_in, rw_in;
   logic signed [RW-1:0] rx_ff, ry_ff, rz_ff, rw_ff;
   quat_type             quat_ff;
   logic                 valid_ff;

   for (genvar i = 0; i < 4; i++) begin : g_row
      for (genvar j = 0; j < 4; j++) begin : g_col
         assign p[i][j] = SW'(prod_in[i][j]);
      end
   end

   // Hamilton product terms, rounding bias folded in
   always_comb begin
      sum_x = p[IDX_Z][IDX_Y] - p[IDX_Y][IDX_Z] + p[IDX_X][IDX_S] - p[IDX_W][IDX_X] + RND;
      sum_y = p[IDX_X][IDX_Z] - p[IDX_Z][IDX_X] + p[IDX_Y][IDX_S] - p[IDX_W][IDX_Y] + RND;
      sum_z = p[IDX_Y][IDX_X] - p[IDX_X][IDX_Y] + p[IDX_Z][IDX_S] - p[IDX_W][IDX_Z] + RND;
      sum_w = p[IDX_W][IDX_S] - p[IDX_X][IDX_X] - p[IDX_Y][IDX_Y] - p[IDX_Z][IDX_Z] + RND;
      rx_in = sum_x[SW-1:FRAC];
      ry_in = sum_y[SW-1:FRAC];
      rz_in = sum_z[SW-1:FRAC];
      rw_in = sum_w[SW-1:FRAC];
   end

   // Advance the stage; hold the beat while the next stage is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && valid_in) begin
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         rz_ff   <= rz_in;
         rw_ff   <= rw_in;
         quat_ff <= quat_in;
      end
   end

   assign valid_out = valid_ff;
   assign quat_out  = quat_ff;
   assign r_x       = rx_ff;
   assign r_y       = ry_ff;
   assign r_z       = rz_ff;
   assign r_w       = rw_ff;

endmodule

[rtl/qvr_saturate.sv]
// ----------------------------------------------------------------------------
// qvr_saturate
// Output stage: clamps the three rotated components to the vector range,
// flags any clamp and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module qvr_saturate #(
   parameter int IW = 40,
   parameter int OW = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 valid_in,
   input  logic signed [IW-1:0] in_x,
   input  logic signed [IW-1:0] in_y,
   input  logic signed [IW-1:0] in_z,
   output logic                 valid_out,
   output logic signed [OW-1:0] out_x,
   output logic signed [OW-1:0] out_y,
   output logic signed [OW-1:0] out_z,
   output logic                 clip_out
);

   localparam logic signed [OW-1:0] VMAX = {1'b0, {(OW-1){1'b1}}};
   localparam logic signed [OW-1:0] VMIN = {1'b1, {(OW-1){1'b0}}};

   logic signed [IW-1:0] in_val [3];
   logic signed [OW-1:0] out_in [3];
   logic signed [OW-1:0] out_ff [3];
   logic [2:0]           over;
   logic                 clip_ff;
   logic                 valid_ff;

   assign in_val[0] = in_x;
   assign in_val[1] = in_y;
   assign in_val[2] = in_z;

   // Clamp each component when its upper bits are not a pure sign extension
   for (genvar k = 0; k < 3; k++) begin : g_comp
      if (IW > OW) begin : g_sat
         logic [IW-OW:0] top_bits;
         assign top_bits  = in_val[k][IW-1:OW-1];
         assign over[k]   = !((&top_bits) || !(|top_bits));
         assign out_in[k] = over[k] ? (in_val[k][IW-1] ? VMIN : VMAX)
                                    : in_val[k][OW-1:0];
      end else begin : g_ext
         assign over[k]   = 1'b0;
         assign out_in[k] = OW'(in_val[k]);
      end
   end

   // Advance the result beat; hold it while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && valid_in) begin
         out_ff  <= out_in;
         clip_ff <= |over;
      end
   end

   assign valid_out = valid_ff;
   assign out_x     = out_ff[0];
   assign out_y     = out_ff[1];
   assign out_z     = out_ff[2];
   assign clip_out  = clip_ff;

endmodule

[bench/quaternion_vector_rotate_unit_tb.sv]
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit_tb
// Self-checking bench for the quaternion vector rotate unit. A directed table
// of rotations (identity, half turns, zero and oversized quaternions, rounding
// ties, saturation) is followed by random quaternion/vector beats. Every
// accepted response beat is checked field by field against a typed-in answer
// or a rotation predictor, with random request gaps and response stalls.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit_tb;
   import qvr_pkg::*;

   localparam int VEC_WIDTH  = 24;
   localparam int QUAT_FRAC  = 14;
   localparam int RAND_BEATS = 1600;
   localparam int BLOCK_LEN  = 64;
   localparam int MODE_SPAN  = 300;
   localparam int DRAIN_WAIT = 20;
   localparam longint VEC_MAX = (64'sd1 <<< (VEC_WIDTH - 1)) - 1;
   localparam longint VEC_MIN = -VEC_MAX - 1;

   typedef logic signed [VEC_WIDTH-1:0] vec_comp_type;

   typedef struct packed {
      quat_type     quat;
      vec_comp_type vec_x;
      vec_comp_type vec_y;
      vec_comp_type vec_z;
   } rot_req_type;

   typedef struct packed {
      vec_comp_type rot_x;
      vec_comp_type rot_y;
      vec_comp_type rot_z;
      logic         clipped;
   } rot_rsp_type;

   // Sideband that travels with each request beat: a typed-in answer, if any
   typedef struct packed {
      logic        typed;
      rot_rsp_type want;
   } beat_note_type;

   typedef struct packed {
      rot_req_type   req;
      beat_note_type note;
   } table_row_type;

   typedef enum int {IDLE_NONE, IDLE_SHORT, IDLE_MIXED} idle_mode_type;
   typedef enum int {MIX_UNIT, MIX_FULL, MIX_EDGE, MIX_SMALL} value_mix_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   quat_comp_type req_quat_x = '0;
   quat_comp_type req_quat_y = '0;
   quat_comp_type req_quat_z = '0;
   quat_comp_type req_quat_s = '0;
   vec_comp_type req_vec_x = '0;
   vec_comp_type req_vec_y = '0;
   vec_comp_type req_vec_z = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   vec_comp_type rsp_rot_x;
   vec_comp_type rsp_rot_y;
   vec_comp_type rsp_rot_z;
   logic         rsp_clipped;

   beat_note_type req_note = '0;
   rot_rsp_type   rotation_q[$];
   table_row_type stim_table[$];
   int            mismatch_count = 0;
   int            rsp_count = 0;

   quaternion_vector_rotate_unit #(
      .VEC_WIDTH(VEC_WIDTH),
      .QUAT_FRAC(QUAT_FRAC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_quat_x (req_quat_x),
      .req_quat_y (req_quat_y),
      .req_quat_z (req_quat_z),
      .req_quat_s (req_quat_s),
      .req_vec_x  (req_vec_x),
      .req_vec_y  (req_vec_y),
      .req_vec_z  (req_vec_z),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_rot_x  (rsp_rot_x),
      .rsp_rot_y  (rsp_rot_y),
      .rsp_rot_z  (rsp_rot_z),
      .rsp_clipped(rsp_clipped)
   );

   // Run the clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shift an exact sum down by the fraction width, ties toward plus infinity
   function automatic longint round_down(input longint acc);
      return (acc + (64'sd1 <<< (QUAT_FRAC - 1))) >>> QUAT_FRAC;
   endfunction

   function automatic vec_comp_type clamp_vec(input longint v, inout logic clip);
      if (v > VEC_MAX) begin
         clip = 1'b1;
         return vec_comp_type'(VEC_MAX);
      end
      if (v < VEC_MIN) begin
         clip = 1'b1;
         return vec_comp_type'(VEC_MIN);
      end
      return vec_comp_type'(v);
   endfunction

   // Predict the rotated vector: vector part of q * (v,0) * conj(q)
   function automatic rot_rsp_type rotate_vector(input rot_req_type r);
      longint      qx, qy, qz, qs, vx, vy, vz;
      longint      tx, ty, tz, tw;
      logic        clip;
      rot_rsp_type o;
      qx = r.quat.x;
      qy = r.quat.y;
      qz = r.quat.z;
      qs = r.quat.s;
      vx = r.vec_x;
      vy = r.vec_y;
      vz = r.vec_z;
      clip = 1'b0;
      // first Hamilton product, kept exact after rounding
      tx = round_down(vz * qy - vy * qz + vx * qs);
      ty = round_down(vx * qz - vz * qx + vy * qs);
      tz = round_down(vy * qx - vx * qy + vz * qs);
      tw = round_down(-vx * qx - vy * qy - vz * qz);
      // second product against the conjugate, saturated
      o.rot_x = clamp_vec(round_down(tz * qy - ty * qz + tx * qs - tw * qx), clip);
      o.rot_y = clamp_vec(round_down(tx * qz - tz * qx + ty * qs - tw * qy), clip);
      o.rot_z = clamp_vec(round_down(ty * qx - tx * qy + tz * qs - tw * qz), clip);
      o.clipped = clip;
      return o;
   endfunction

   // No idles, short idles, or by default mostly short idles with now and then a long one
   function automatic int idle_length(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            return 0;
         end
         IDLE_SHORT: begin
            return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 2)) : 0;
         end
         default: begin
            if ($urandom_range(0, 15) == 0) begin
               return int'($urandom_range(10, 40));
            end
            return int'($urandom_range(0, 3));
         end
      endcase
   endfunction

   function automatic quat_comp_type random_quat_comp(input value_mix_type mix);
      case (mix)
         MIX_UNIT: begin
            return quat_comp_type'(int'($urandom_range(0, 32768)) - 16384);
         end
         MIX_FULL: begin
            return quat_comp_type'($urandom);
         end
         MIX_EDGE: begin
            case ($urandom_range(0, 5))
               0: return quat_comp_type'(0);
               1: return quat_comp_type'(16384);
               2: return quat_comp_type'(-16384);
               3: return quat_comp_type'(-32768);
               4: return quat_comp_type'(32767);
               default: return quat_comp_type'(-1);
            endcase
         end
         default: begin
            return quat_comp_type'(int'($urandom_range(0, 512)) - 256);
         end
      endcase
   endfunction

   function automatic vec_comp_type random_vec_comp(input value_mix_type mix);
      case (mix)
         MIX_EDGE: begin
            case ($urandom_range(0, 4))
               0: return vec_comp_type'(0);
               1: return vec_comp_type'(VEC_MAX);
               2: return vec_comp_type'(VEC_MIN);
               3: return vec_comp_type'(1);
               default: return vec_comp_type'(-1);
            endcase
         end
         MIX_SMALL: begin
            return vec_comp_type'(int'($urandom_range(0, 8192)) - 4096);
         end
         default: begin
            return vec_comp_type'($urandom);
         end
      endcase
   endfunction

   // Each component mostly follows the beat's mix, sometimes its own
   function automatic rot_req_type random_request();
      rot_req_type   r;
      value_mix_type qmix, vmix;
      qmix = value_mix_type'($urandom_range(0, 3));
      vmix = value_mix_type'($urandom_range(0, 3));
      r.quat.x = random_quat_comp(($urandom_range(0, 3) == 0) ?
                                  value_mix_type'($urandom_range(0, 3)) : qmix);
      r.quat.y = random_quat_comp(($urandom_range(0, 3) == 0) ?
                                  value_mix_type'($urandom_range(0, 3)) : qmix);
      r.quat.z = random_quat_comp(($urandom_range(0, 3) == 0) ?
                                  value_mix_type'($urandom_range(0, 3)) : qmix);
      r.quat.s = random_quat_comp(($urandom_range(0, 3) == 0) ?
                                  value_mix_type'($urandom_range(0, 3)) : qmix);
      r.vec_x = random_vec_comp(($urandom_range(0, 3) == 0) ?
                                value_mix_type'($urandom_range(0, 3)) : vmix);
      r.vec_y = random_vec_comp(($urandom_range(0, 3) == 0) ?
                                value_mix_type'($urandom_range(0, 3)) : vmix);
      r.vec_z = random_vec_comp(($urandom_range(0, 3) == 0) ?
                                value_mix_type'($urandom_range(0, 3)) : vmix);
      return r;
   endfunction

   // Directed row checked against the predictor
   task automatic add_row(input int qx, qy, qz, qs, input int vx, vy, vz);
      table_row_type row;
      row = '0;
      row.req.quat.x = quat_comp_type'(qx);
      row.req.quat.y = quat_comp_type'(qy);
      row.req.quat.z = quat_comp_type'(qz);
      row.req.quat.s = quat_comp_type'(qs);
      row.req.vec_x = vec_comp_type'(vx);
      row.req.vec_y = vec_comp_type'(vy);
      row.req.vec_z = vec_comp_type'(vz);
      stim_table.push_back(row);
   endtask

   // Directed row with its answer typed in
   task automatic add_checked_row(input int qx, qy, qz, qs, input int vx, vy, vz,
                                  input int rx, ry, rz, input logic clip);
      int last;
      add_row(qx, qy, qz, qs, vx, vy, vz);
      last = stim_table.size() - 1;
      stim_table[last].note.typed = 1'b1;
      stim_table[last].note.want.rot_x = vec_comp_type'(rx);
      stim_table[last].note.want.rot_y = vec_comp_type'(ry);
      stim_table[last].note.want.rot_z = vec_comp_type'(rz);
      stim_table[last].note.want.clipped = clip;
   endtask

   // Present one request beat and hold it until accepted
   task automatic send_rotation(input rot_req_type beat, input beat_note_type note);
      req_valid  <= 1'b1;
      req_quat_x <= beat.quat.x;
      req_quat_y <= beat.quat.y;
      req_quat_z <= beat.quat.z;
      req_quat_s <= beat.quat.s;
      req_vec_x  <= beat.vec_x;
      req_vec_y  <= beat.vec_y;
      req_vec_z  <= beat.vec_z;
      req_note   <= note;
      do begin
         @(posedge clock);
      end while (!(req_valid && !req_stall));
   endtask

   task automatic idle_gap(input idle_mode_type mode);
      int n;
      n = idle_length(mode);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic report_mismatch(input rot_rsp_type want, input rot_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $write("rotation %0d mismatch: expected x=%0d y=%0d z=%0d clipped=%0b, ",
                rsp_count, want.rot_x, want.rot_y, want.rot_z, want.clipped);
         $display("got x=%0d y=%0d z=%0d clipped=%0b",
                  got.rot_x, got.rot_y, got.rot_z, got.clipped);
      end
   endtask

   // Check response beats first, then log the prediction for a request beat
   always @(posedge clock) begin
      rot_rsp_type got;
      rot_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.rot_x = rsp_rot_x;
            got.rot_y = rsp_rot_y;
            got.rot_z = rsp_rot_z;
            got.clipped = rsp_clipped;
            if (rotation_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("rotation %0d: response beat with nothing outstanding", rsp_count);
               end
            end else begin
               want = rotation_q.pop_front();
               if (got.rot_x !== want.rot_x || got.rot_y !== want.rot_y ||
                   got.rot_z !== want.rot_z || got.clipped !== want.clipped) begin
                  report_mismatch(want, got);
               end
            end
            rsp_count++;
         end
         if (req_valid && !req_stall) begin
            if (req_note.typed) begin
               rotation_q.push_back(req_note.want);
            end else begin
               rotation_q.push_back(rotate_vector({req_quat_x, req_quat_y, req_quat_z,
                                                   req_quat_s, req_vec_x, req_vec_y,
                                                   req_vec_z}));
            end
         end
      end
   end

   // Stall the response channel in bursts; switch pattern every so often
   always @(posedge clock) begin
      static int            stall_cycle = 0;
      static int            stall_hold = 0;
      static idle_mode_type stall_mode = IDLE_MIXED;
      stall_cycle++;
      if (stall_cycle % MODE_SPAN == 0) begin
         stall_mode = idle_mode_type'($urandom_range(0, 2));
      end
      if (stall_hold > 0) begin
         stall_hold--;
      end else if (stall_mode == IDLE_NONE) begin
         rsp_stall  <= 1'b0;
         stall_hold = 16;
      end else begin
         rsp_stall  <= ($urandom_range(0, 2) == 0);
         stall_hold = idle_length(stall_mode);
      end
   end

   // Stimulus: reset, directed table, random beats, drain
   initial begin
      idle_mode_type mode;
      beat_note_type no_note;
      no_note = '0;
      mode = IDLE_MIXED;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero quaternion collapses everything
      add_checked_row(0, 0, 0, 0, 8388607, 8388607, 8388607, 0, 0, 0, 1'b0);
      // identity and minus identity leave the vector alone
      add_checked_row(0, 0, 0, 16384, 8388607, -8388608, 1, 8388607, -8388608, 1, 1'b0);
      add_checked_row(0, 0, 0, 16384, -1, 0, -8388608, -1, 0, -8388608, 1'b0);
      add_checked_row(0, 0, 0, -16384, 123456, -654321, 7, 123456, -654321, 7, 1'b0);
      // half turns about x, y and z; negating the minimum saturates
      add_checked_row(16384, 0, 0, 0, 5, -8388608, 8388607, 5, 8388607, -8388607, 1'b1);
      add_checked_row(-16384, 0, 0, 0, 1, 1, 1, 1, -1, -1, 1'b0);
      add_row(0, 16384, 0, 0, 8388607, -8388608, 77);
      add_row(0, 0, 16384, 0, -8388608, 8388607, -77);
      // oversized quaternions scale by the squared norm
      add_row(-32768, -32768, -32768, -32768, 8388607, 8388607, 8388607);
      add_row(32767, 32767, 32767, 32767, -8388608, -8388608, -8388608);
      add_row(0, 0, 0, -32768, 1, 2, 3);
      add_row(16384, 16384, 16384, 16384, 1000, -2000, 3000);
      add_row(0, -32768, 0, 0, -8388608, -8388608, -8388608);
      add_row(32767, -32768, 32767, -32768, 8388607, -8388608, 8388607);
      // rounding ties after each product
      add_row(0, 0, 0, 8192, 1, -1, 3);
      add_row(0, 0, 0, 8192, -3, -2, -1);
      add_row(1, -1, 1, -1, 8388607, 8388607, 8388607);
      add_row(0, 0, 0, 1, 8388607, -8388608, 8191);
      add_row(0, 0, 0, 16383, -8388608, 8388607, 1);
      add_row(11585, 0, 0, 11585, 0, 8388607, 0);
      add_row(-1, -1, -1, -1, -1, -1, -1);

      foreach (stim_table[i]) begin
         send_rotation(stim_table[i].req, stim_table[i].note);
         idle_gap(IDLE_MIXED);
      end

      for (int n = 0; n < RAND_BEATS; n++) begin
         if (n % BLOCK_LEN == 0) begin
            mode = idle_mode_type'($urandom_range(0, 2));
         end
         send_rotation(random_request(), no_note);
         idle_gap(mode);
      end
      req_valid <= 1'b0;

      // Wait for the pipeline to drain, then wait on for stray responses
      @(posedge clock);
      while (rotation_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0 && rotation_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Hard stop for a hung handshake
   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[files.f]
rtl/qvr_pkg.sv
rtl/qvr_prod_stage.sv
rtl/qvr_round_sum.sv
rtl/qvr_saturate.sv
rtl/quaternion_vector_rotate_unit.sv
bench/quaternion_vector_rotate_unit_tb.sv
